[sv/rv32dec_pkg.sv]
// Shared types, opcode constants and match tables for the RV32 instruction decoder.
`default_nettype none

package rv32dec_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_IDX_MULTIPLY   = 3'd0;
  localparam logic [2:0] CFG_IDX_BITMANIP   = 3'd1;
  localparam logic [2:0] CFG_IDX_COMPRESSED = 3'd2;
  localparam logic [2:0] CFG_IDX_ATOMIC     = 3'd3;
  localparam logic [2:0] CFG_IDX_EMBEDDED   = 3'd4;

  // Major opcodes (bits 6:0)
  localparam logic [6:0] MAJ_LOAD         = 7'h03;
  localparam logic [6:0] MAJ_FP_LOAD      = 7'h07;
  localparam logic [6:0] MAJ_FENCE        = 7'h0f;
  localparam logic [6:0] MAJ_OP_IMM       = 7'h13;
  localparam logic [6:0] MAJ_ADD_UPPER_PC = 7'h17;
  localparam logic [6:0] MAJ_STORE        = 7'h23;
  localparam logic [6:0] MAJ_FP_STORE     = 7'h27;
  localparam logic [6:0] MAJ_AMO          = 7'h2f;
  localparam logic [6:0] MAJ_OP           = 7'h33;
  localparam logic [6:0] MAJ_LUI          = 7'h37;
  localparam logic [6:0] MAJ_FP_MADD      = 7'h43;
  localparam logic [6:0] MAJ_FP_MSUB      = 7'h47;
  localparam logic [6:0] MAJ_FP_NMSUB     = 7'h4b;
  localparam logic [6:0] MAJ_FP_NMADD     = 7'h4f;
  localparam logic [6:0] MAJ_FP_ARITH     = 7'h53;
  localparam logic [6:0] MAJ_COND_BRANCH  = 7'h63;
  localparam logic [6:0] MAJ_JUMP_REG     = 7'h67;
  localparam logic [6:0] MAJ_JAL          = 7'h6f;
  localparam logic [6:0] MAJ_SYSTEM       = 7'h73;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT = 7'h20;

  // Instruction classes
  localparam logic [3:0] CLS_ILLEGAL    = 4'd0;
  localparam logic [3:0] CLS_IMMEDIATE  = 4'd1;
  localparam logic [3:0] CLS_REGISTER   = 4'd2;
  localparam logic [3:0] CLS_MULDIV     = 4'd3;
  localparam logic [3:0] CLS_BITMANIP   = 4'd4;
  localparam logic [3:0] CLS_LOAD       = 4'd5;
  localparam logic [3:0] CLS_STORE      = 4'd6;
  localparam logic [3:0] CLS_BRANCH     = 4'd7;
  localparam logic [3:0] CLS_JUMP       = 4'd8;
  localparam logic [3:0] CLS_UPPER      = 4'd9;
  localparam logic [3:0] CLS_FENCE      = 4'd10;
  localparam logic [3:0] CLS_SYSTEM     = 4'd11;
  localparam logic [3:0] CLS_FLOAT      = 4'd12;
  localparam logic [3:0] CLS_COMPRESSED = 4'd13;
  localparam logic [3:0] CLS_ATOMIC     = 4'd14;

  // Mnemonic numbers (first of each run)
  localparam logic [6:0] OP_ILLEGAL    = 7'd0;
  localparam logic [6:0] OP_SRAI       = 7'd9;
  localparam logic [6:0] OP_SUB        = 7'd11;
  localparam logic [6:0] OP_SRA        = 7'd17;
  localparam logic [6:0] OP_MUL        = 7'd20;
  localparam logic [6:0] OP_BSETI      = 7'd28;
  localparam logic [6:0] OP_CLZ        = 7'd33;
  localparam logic [6:0] OP_ZEXT_H     = 7'd40;
  localparam logic [6:0] OP_SH1ADD     = 7'd41;
  localparam logic [6:0] OP_LB         = 7'd60;
  localparam logic [6:0] OP_SB         = 7'd65;
  localparam logic [6:0] OP_BEQ        = 7'd68;
  localparam logic [6:0] OP_JAL        = 7'd74;
  localparam logic [6:0] OP_JALR       = 7'd75;
  localparam logic [6:0] OP_LUI        = 7'd76;
  localparam logic [6:0] OP_AUIPC      = 7'd77;
  localparam logic [6:0] OP_FENCE      = 7'd78;
  localparam logic [6:0] OP_SYSTEM     = 7'd80;
  localparam logic [6:0] OP_FLOAT      = 7'd81;
  localparam logic [6:0] OP_COMPRESSED = 7'd82;
  localparam logic [6:0] OP_ATOMIC     = 7'd83;

  // Per-funct3 mnemonics for OP-IMM and OP
  localparam logic [6:0] OPIMM_OPS [8] = '{7'd1, 7'd7, 7'd2, 7'd3, 7'd4, 7'd8, 7'd5, 7'd6};
  localparam logic [6:0] OP_BASE   [8] = '{7'd10, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16,
                                           7'd18, 7'd19};

  // Register-use bits
  localparam logic [2:0] USE_RD  = 3'b001;
  localparam logic [2:0] USE_RS1 = 3'b010;
  localparam logic [2:0] USE_RS2 = 3'b100;

  // Bit-manipulation match masks and patterns
  localparam logic [31:0] MASK_R      = 32'hfe00707f;
  localparam logic [31:0] MASK_UNARY  = 32'hfff0707f;
  localparam logic [31:0] ZEXT_H_PAT  = 32'h08004033;

  localparam int unsigned NUM_BMI_SHIFT = 5;
  localparam int unsigned NUM_BMI_UNARY = 7;
  localparam int unsigned NUM_BMR       = 19;

  localparam logic [31:0] BMI_SHIFT_PAT [NUM_BMI_SHIFT] = '{
    32'h28001013, 32'h48001013, 32'h68001013, 32'h48005013, 32'h60005013
  };
  localparam logic [31:0] BMI_UNARY_PAT [NUM_BMI_UNARY] = '{
    32'h60001013, 32'h60101013, 32'h60201013, 32'h60401013, 32'h60501013,
    32'h28705013, 32'h69805013
  };
  localparam logic [31:0] BMR_PAT [NUM_BMR] = '{
    32'h20002033, 32'h20004033, 32'h20006033, 32'h40007033, 32'h40006033,
    32'h40004033, 32'h60001033, 32'h60005033, 32'h0a004033, 32'h0a005033,
    32'h0a006033, 32'h0a007033, 32'h0a001033, 32'h0a002033, 32'h0a003033,
    32'h28001033, 32'h48001033, 32'h48005033, 32'h68001033
  };

  typedef struct packed {
    logic multiply;
    logic bitmanip;
    logic compressed;
    logic atomic;
    logic embedded;
  } cfg_t;

  typedef struct packed {
    logic        illegal;
    logic [3:0]  cls;
    logic [6:0]  op;
    logic [31:0] imm;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  uses;
    logic        short_len;
    logic        deleg;
  } desc_t;

endpackage

`default_nettype wire

[sv/rv32dec_cfg.sv]
// Configuration register bank for the RV32 instruction decoder.
`default_nettype none

module rv32dec_cfg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic               cfg_data_i,
  output rv32dec_pkg::cfg_t       cfg_o
);

  rv32dec_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rv32dec_pkg::CFG_IDX_MULTIPLY:   cfg_d.multiply   = cfg_data_i;
        rv32dec_pkg::CFG_IDX_BITMANIP:   cfg_d.bitmanip   = cfg_data_i;
        rv32dec_pkg::CFG_IDX_COMPRESSED: cfg_d.compressed = cfg_data_i;
        rv32dec_pkg::CFG_IDX_ATOMIC:     cfg_d.atomic     = cfg_data_i;
        rv32dec_pkg::CFG_IDX_EMBEDDED:   cfg_d.embedded   = cfg_data_i;
        default: ; // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.multiply   <= 1'b1;
      cfg_q.bitmanip   <= 1'b1;
      cfg_q.compressed <= 1'b1;
      cfg_q.atomic     <= 1'b1;
      cfg_q.embedded   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/rv32dec_logic.sv]
// Combinational decode of one instruction word into a descriptor.
`default_nettype none

module rv32dec_logic (
  input  wire logic [31:0]        word_i,
  input  wire rv32dec_pkg::cfg_t  cfg_i,
  output rv32dec_pkg::desc_t      desc_o
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, shamt;

  logic       sh_found, un_found, bmr_found;
  logic [2:0] sh_idx, un_idx;
  logic [4:0] bmr_idx;

  logic        hit, deleg, short_len, rve_bad;
  logic [3:0]  cls;
  logic [6:0]  op;
  logic [2:0]  uses;
  logic [31:0] imm;

  assign opc = word_i[6:0];
  assign f3  = word_i[14:12];
  assign f7  = word_i[31:25];

  assign imm_i = {{20{word_i[31]}}, word_i[31:20]};
  assign imm_s = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
  assign imm_b = {{19{word_i[31]}}, word_i[31], word_i[7], word_i[30:25], word_i[11:8], 1'b0};
  assign imm_j = {{11{word_i[31]}}, word_i[31], word_i[19:12], word_i[20], word_i[30:21], 1'b0};
  assign imm_u = {word_i[31:12], 12'b0};
  assign shamt = {27'b0, word_i[24:20]};

  // Pattern searches; lowest matching entry wins
  always_comb begin
    sh_found = 1'b0;
    sh_idx   = '0;
    for (int i = rv32dec_pkg::NUM_BMI_SHIFT - 1; i >= 0; i--) begin
      if ((word_i & rv32dec_pkg::MASK_R) == rv32dec_pkg::BMI_SHIFT_PAT[i]) begin
        sh_found = 1'b1;
        sh_idx   = 3'(i);
      end
    end
  end

  always_comb begin
    un_found = 1'b0;
    un_idx   = '0;
    for (int i = rv32dec_pkg::NUM_BMI_UNARY - 1; i >= 0; i--) begin
      if ((word_i & rv32dec_pkg::MASK_UNARY) == rv32dec_pkg::BMI_UNARY_PAT[i]) begin
        un_found = 1'b1;
        un_idx   = 3'(i);
      end
    end
  end

  always_comb begin
    bmr_found = 1'b0;
    bmr_idx   = '0;
    for (int i = rv32dec_pkg::NUM_BMR - 1; i >= 0; i--) begin
      if ((word_i & rv32dec_pkg::MASK_R) == rv32dec_pkg::BMR_PAT[i]) begin
        bmr_found = 1'b1;
        bmr_idx   = 5'(i);
      end
    end
  end

  always_comb begin
    hit       = 1'b0;
    deleg     = 1'b0;
    short_len = 1'b0;
    cls       = rv32dec_pkg::CLS_ILLEGAL;
    op        = rv32dec_pkg::OP_ILLEGAL;
    uses      = '0;
    imm       = '0;

    if (cfg_i.compressed && (word_i[1:0] != 2'b11)) begin
      hit = 1'b1; deleg = 1'b1; short_len = 1'b1;
      cls = rv32dec_pkg::CLS_COMPRESSED;
      op  = rv32dec_pkg::OP_COMPRESSED;
    end else begin
      case (opc)
        rv32dec_pkg::MAJ_OP_IMM: begin
          if (f3 == 3'd1 || f3 == 3'd5) begin
            if (f7 == rv32dec_pkg::F7_ZERO || (f3 == 3'd5 && f7 == rv32dec_pkg::F7_ALT)) begin
              imm = shamt; hit = 1'b1;
              cls = rv32dec_pkg::CLS_IMMEDIATE;
              op  = (f7 == rv32dec_pkg::F7_ALT) ? rv32dec_pkg::OP_SRAI
                                                : rv32dec_pkg::OPIMM_OPS[f3];
              uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1;
            end else if (cfg_i.bitmanip && sh_found) begin
              imm = shamt; hit = 1'b1;
              cls = rv32dec_pkg::CLS_BITMANIP;
              op  = rv32dec_pkg::OP_BSETI + 7'(sh_idx);
              uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1;
            end else if (cfg_i.bitmanip && un_found) begin
              imm = shamt; hit = 1'b1;
              cls = rv32dec_pkg::CLS_BITMANIP;
              op  = rv32dec_pkg::OP_CLZ + 7'(un_idx);
              uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1;
            end
          end else begin
            imm = imm_i; hit = 1'b1;
            cls = rv32dec_pkg::CLS_IMMEDIATE;
            op  = rv32dec_pkg::OPIMM_OPS[f3];
            uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1;
          end
        end
        rv32dec_pkg::MAJ_OP: begin
          if (f7 == rv32dec_pkg::F7_ZERO) begin
            hit = 1'b1;
            cls = rv32dec_pkg::CLS_REGISTER;
            op  = rv32dec_pkg::OP_BASE[f3];
            uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1 | rv32dec_pkg::USE_RS2;
          end else if (f7 == rv32dec_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
            hit = 1'b1;
            cls = rv32dec_pkg::CLS_REGISTER;
            op  = (f3 == 3'd0) ? rv32dec_pkg::OP_SUB : rv32dec_pkg::OP_SRA;
            uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1 | rv32dec_pkg::USE_RS2;
          end else if (f7 == rv32dec_pkg::F7_MULDIV) begin
            if (cfg_i.multiply) begin
              hit = 1'b1;
              cls = rv32dec_pkg::CLS_MULDIV;
              op  = rv32dec_pkg::OP_MUL + 7'(f3);
              uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1 | rv32dec_pkg::USE_RS2;
            end
          end else if (cfg_i.bitmanip) begin
            if ((word_i & rv32dec_pkg::MASK_UNARY) == rv32dec_pkg::ZEXT_H_PAT) begin
              hit = 1'b1;
              cls = rv32dec_pkg::CLS_BITMANIP;
              op  = rv32dec_pkg::OP_ZEXT_H;
              uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1;
            end else if (bmr_found) begin
              hit = 1'b1;
              cls = rv32dec_pkg::CLS_BITMANIP;
              op  = rv32dec_pkg::OP_SH1ADD + 7'(bmr_idx);
              uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1 | rv32dec_pkg::USE_RS2;
            end
          end
        end
        rv32dec_pkg::MAJ_LOAD: begin
          imm = imm_i;   // kept even when illegal
          if (f3 != 3'd3 && f3 < 3'd6) begin
            hit = 1'b1;
            cls = rv32dec_pkg::CLS_LOAD;
            op  = (f3 < 3'd3) ? rv32dec_pkg::OP_LB + 7'(f3)
                              : rv32dec_pkg::OP_LB + 7'(f3) - 7'd1;
            uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1;
          end
        end
        rv32dec_pkg::MAJ_STORE: begin
          imm = imm_s;
          if (f3 < 3'd3) begin
            hit = 1'b1;
            cls = rv32dec_pkg::CLS_STORE;
            op  = rv32dec_pkg::OP_SB + 7'(f3);
            uses = rv32dec_pkg::USE_RS1 | rv32dec_pkg::USE_RS2;
          end
        end
        rv32dec_pkg::MAJ_COND_BRANCH: begin
          imm = imm_b;
          if (f3 != 3'd2 && f3 != 3'd3) begin
            hit = 1'b1;
            cls = rv32dec_pkg::CLS_BRANCH;
            op  = (f3 < 3'd2) ? rv32dec_pkg::OP_BEQ + 7'(f3)
                              : rv32dec_pkg::OP_BEQ + 7'(f3) - 7'd2;
            uses = rv32dec_pkg::USE_RS1 | rv32dec_pkg::USE_RS2;
          end
        end
        rv32dec_pkg::MAJ_JAL: begin
          imm = imm_j; hit = 1'b1;
          cls = rv32dec_pkg::CLS_JUMP;
          op  = rv32dec_pkg::OP_JAL;
          uses = rv32dec_pkg::USE_RD;
        end
        rv32dec_pkg::MAJ_JUMP_REG: begin
          if (f3 == 3'd0) begin
            imm = imm_i; hit = 1'b1;
            cls = rv32dec_pkg::CLS_JUMP;
            op  = rv32dec_pkg::OP_JALR;
            uses = rv32dec_pkg::USE_RD | rv32dec_pkg::USE_RS1;
          end
        end
        rv32dec_pkg::MAJ_LUI: begin
          imm = imm_u; hit = 1'b1;
          cls = rv32dec_pkg::CLS_UPPER;
          op  = rv32dec_pkg::OP_LUI;
          uses = rv32dec_pkg::USE_RD;
        end
        rv32dec_pkg::MAJ_ADD_UPPER_PC: begin
          imm = imm_u; hit = 1'b1;
          cls = rv32dec_pkg::CLS_UPPER;
          op  = rv32dec_pkg::OP_AUIPC;
          uses = rv32dec_pkg::USE_RD;
        end
        rv32dec_pkg::MAJ_FENCE: begin
          if (f3 < 3'd2) begin
            hit = 1'b1;
            cls = rv32dec_pkg::CLS_FENCE;
            op  = rv32dec_pkg::OP_FENCE + 7'(f3);
          end
        end
        rv32dec_pkg::MAJ_SYSTEM: begin
          hit = 1'b1; deleg = 1'b1;
          cls = rv32dec_pkg::CLS_SYSTEM;
          op  = rv32dec_pkg::OP_SYSTEM;
        end
        rv32dec_pkg::MAJ_FP_LOAD, rv32dec_pkg::MAJ_FP_STORE, rv32dec_pkg::MAJ_FP_MADD,
        rv32dec_pkg::MAJ_FP_MSUB, rv32dec_pkg::MAJ_FP_NMSUB, rv32dec_pkg::MAJ_FP_NMADD,
        rv32dec_pkg::MAJ_FP_ARITH: begin
          hit = 1'b1; deleg = 1'b1;
          cls = rv32dec_pkg::CLS_FLOAT;
          op  = rv32dec_pkg::OP_FLOAT;
        end
        rv32dec_pkg::MAJ_AMO: begin
          if (cfg_i.atomic) begin
            hit = 1'b1; deleg = 1'b1;
            cls = rv32dec_pkg::CLS_ATOMIC;
            op  = rv32dec_pkg::OP_ATOMIC;
          end
        end
        default: ;
      endcase
    end
  end

  // RVE: any used register at x16 or above kills class and op, keeps imm and uses
  assign rve_bad = cfg_i.embedded &&
                   ((uses[0] && word_i[11]) || (uses[1] && word_i[19]) ||
                    (uses[2] && word_i[24]));

  always_comb begin
    desc_o.illegal   = !hit || rve_bad;
    desc_o.cls       = (hit && !rve_bad) ? cls : rv32dec_pkg::CLS_ILLEGAL;
    desc_o.op        = (hit && !rve_bad) ? op  : rv32dec_pkg::OP_ILLEGAL;
    desc_o.imm       = imm;
    desc_o.rd        = word_i[11:7];
    desc_o.rs1       = word_i[19:15];
    desc_o.rs2       = word_i[24:20];
    desc_o.uses      = uses;
    desc_o.short_len = short_len;
    desc_o.deleg     = deleg;
  end

endmodule

`default_nettype wire

[sv/rv32_instruction_decoder_core.sv]
// Top level of the RV32 instruction decoder: input register, decode, result register.
//
// Usage notes
// - Input channel (in_valid_i / in_stall_o / instruction_word_i): one raw 32-bit
//   encoding per transfer. Compressed encodings sit in the low 16 bits.
// - Output channel (out_valid_o / out_stall_i / descriptor fields): one
//   descriptor per input transfer, in order.
// - Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   ready is always high; index 0 multiply, 1 bitmanip, 2 compressed,
//   3 atomic, 4 embedded (RVE). Other indexes are ignored. Write only while
//   the decoder is empty.
// - Path: a transfer taken is held in the input register, decoded, and captured
//   into the result register, which drives the descriptor outputs.
// - Throughput: one instruction per cycle unless out_stall_i holds the result;
//   the whole decode is a single combinational pass between the two registers.
// - Stall: a stalled result holds; the input register keeps taking a new word
//   as long as the result register is free or being drained, so in_stall_o only
//   rises when both stages are full and out_stall_i is high.
// - Reset: both stages empty; config returns to M, B, C and A enabled, RVE off.
`default_nettype none

module rv32_instruction_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic        cfg_data_i,
  // instruction in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instruction_word_i,
  // descriptor out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             illegal_o,
  output logic [3:0]       insn_class_o,
  output logic [6:0]       op_number_o,
  output logic [31:0]      immediate_o,
  output logic [4:0]       dest_reg_o,
  output logic [4:0]       src1_reg_o,
  output logic [4:0]       src2_reg_o,
  output logic [2:0]       uses_mask_o,
  output logic             short_length_o,
  output logic             delegated_o
);

  rv32dec_pkg::cfg_t  cfg;
  rv32dec_pkg::desc_t dec_desc;
  rv32dec_pkg::desc_t s2_desc_q;

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_word_q;
  logic        s2_valid_q, s2_valid_d;
  logic        s1_load, s2_load;

  rv32dec_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Result register free when empty or being taken this cycle
  assign s2_load = !s2_valid_q || !out_stall_i;
  // Input register free when empty or moving into the result register
  assign s1_load = !s1_valid_q || s2_load;

  assign in_stall_o = !s1_load;

  assign s1_valid_d = s1_load ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_load ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_word_q <= instruction_word_i;
    end
    if (s2_load && s1_valid_q) begin
      s2_desc_q <= dec_desc;
    end
  end

  rv32dec_logic u_logic (
    .word_i (s1_word_q),
    .cfg_i  (cfg),
    .desc_o (dec_desc)
  );

  assign out_valid_o    = s2_valid_q;
  assign illegal_o      = s2_desc_q.illegal;
  assign insn_class_o   = s2_desc_q.cls;
  assign op_number_o    = s2_desc_q.op;
  assign immediate_o    = s2_desc_q.imm;
  assign dest_reg_o     = s2_desc_q.rd;
  assign src1_reg_o     = s2_desc_q.rs1;
  assign src2_reg_o     = s2_desc_q.rs2;
  assign uses_mask_o    = s2_desc_q.uses;
  assign short_length_o = s2_desc_q.short_len;
  assign delegated_o    = s2_desc_q.deleg;

  // Illegal and class 0 always go together
  a_illegal_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (illegal_o == (insn_class_o == rv32dec_pkg::CLS_ILLEGAL)) &&
                    (!illegal_o || op_number_o == rv32dec_pkg::OP_ILLEGAL))
    else $error("illegal flag disagrees with class/op");

  // Delegated descriptors carry no immediate and no register use
  a_deleg_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && delegated_o |-> !illegal_o && immediate_o == 32'd0 &&
                                   uses_mask_o == 3'd0)
    else $error("delegated descriptor not clean");

  // Short length only for the compressed class
  a_short_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && short_length_o |-> delegated_o &&
                                      insn_class_o == rv32dec_pkg::CLS_COMPRESSED)
    else $error("short length outside compressed class");

  // A full input register that cannot move keeps its word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_load |=> s1_valid_q && $stable(s1_word_q))
    else $error("input register lost a stalled word");

  // An accepted word always lands in the input register
  a_s1_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted transfer not captured");

endmodule

`default_nettype wire
